/* hdl/bfa_pkg.sv */
// Package with shared constants, types and a helper function of the bitmap allocator.
package bfa_pkg;

    localparam int MAP_BYTES  = 512;
    localparam int MAP_AW     = $clog2(MAP_BYTES);
    localparam int BYTE_W     = 8;
    localparam int BIT_W      = $clog2(BYTE_W);
    localparam int IN_BYTE_W  = 9;
    localparam int LIMIT_W    = 10;
    localparam int BIT_IDX_W  = 12;
    localparam int GROUP_SIZE = 32;
    localparam int GROUP_AW   = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS = MAP_BYTES / GROUP_SIZE;
    localparam int GROUP_NW   = $clog2(NUM_GROUPS);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAP_BYTES);
    localparam logic [BYTE_W-1:0]  FULL_BYTE   = 8'hFF;

    typedef enum logic
    {
        MODE_ALLOC = 1'b0,
        MODE_MARK  = 1'b1
    } mode_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SEL,
        ST_WR,
        ST_OUT
    } state_t;

    function automatic logic [BIT_W-1:0] lowest_clear_bit(input logic [BYTE_W-1:0] v);
        logic [BIT_W-1:0] b;
        b = BIT_W'(BYTE_W - 1);
        for (int i = BYTE_W - 2; i >= 0; i--)
        begin
            if (!v[i])
            begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

/* hdl/bitmap_first_free_allocator.sv */
// Top level of the first-fit bitmap allocator: byte map in memory, full summary in flip-flops.
// An allocate item goes through these steps from acceptance to the next accepted item when the
// output is free: summary group encode, group select with map read, modify and write, result load.
// For a mark item the map write happens in the cycle the item is accepted.
// The result appears on the output in the cycle after the result load and is held until taken.
// After reset a clearing pass zeroes all 512 bytes of the map memory; no item is accepted meanwhile.
module bitmap_first_free_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [8:0] byte_index, [15:9] zero
    input  logic                        s_axis_tuser,  // [0] mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // [11:0] bit_index, [15:12] zero
    output logic                        m_axis_tuser,  // [0] full_res
    input  logic                        cfg_we,
    input  logic [bfa_pkg::LIMIT_W-1:0] cfg_wdata
);

    import bfa_pkg::*;

    state_t                  state_reg, state_next;
    logic [MAP_AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [MAP_BYTES-1:0]    full_vec_reg, full_vec_next;
    logic                    m_valid_reg, m_valid_next;
    logic [BIT_IDX_W-1:0]    m_bit_reg, m_bit_next;
    logic                    m_full_reg, m_full_next;

    logic [NUM_GROUPS-1:0]   grp_free_reg, grp_free_next;
    logic [GROUP_AW-1:0]     grp_low_reg [NUM_GROUPS];
    logic [GROUP_AW-1:0]     grp_low_next [NUM_GROUPS];
    logic [MAP_AW-1:0]       byte_reg, byte_next;
    logic [BIT_IDX_W-1:0]    res_bit_reg, res_bit_next;
    logic                    res_full_reg, res_full_next;

    logic                    ram_we;
    logic [MAP_AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]       ram_wdata;
    logic [BYTE_W-1:0]       ram_rdata;

    logic                    in_accept;
    mode_t                   in_mode;
    logic [IN_BYTE_W-1:0]    in_byte;
    logic [GROUP_NW-1:0]     sel_grp;
    logic [MAP_AW-1:0]       sel_byte;
    logic                    grp_any;
    logic [LIMIT_W-1:0]      limit_sat;
    logic [BIT_W-1:0]        free_bit;
    logic [BYTE_W-1:0]       new_byte;
    logic                    out_free;

    assign in_mode   = mode_t'(s_axis_tuser);
    assign in_byte   = s_axis_tdata[IN_BYTE_W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(16 - BIT_IDX_W){1'b0}}, m_bit_reg};
    assign m_axis_tuser  = m_full_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign limit_sat = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
    assign free_bit  = lowest_clear_bit(ram_rdata);
    assign new_byte  = ram_rdata | (BYTE_W'(1) << free_bit);

    bfa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (sel_byte),
        .rdata (ram_rdata)
    );

    // Per-group encode of the lowest byte that still has a free bit.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_free_next[g] = ~&full_vec_reg[g*GROUP_SIZE +: GROUP_SIZE];
            grp_low_next[g]  = '0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--)
            begin
                if (!full_vec_reg[g*GROUP_SIZE + j])
                begin
                    grp_low_next[g] = GROUP_AW'(j);
                end
            end
        end
    end

    always_comb
    begin
        sel_grp = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                sel_grp = GROUP_NW'(g);
            end
        end
        sel_byte = MAP_AW'({sel_grp, grp_low_reg[sel_grp]});
        grp_any  = |grp_free_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        full_vec_next = full_vec_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_bit_next    = m_bit_reg;
        m_full_next   = m_full_reg;
        byte_next     = byte_reg;
        res_bit_next  = res_bit_reg;
        res_full_next = res_full_reg;
        ram_we        = 1'b0;
        ram_waddr     = byte_reg;
        ram_wdata     = new_byte;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + MAP_AW'(1);
                if (clr_addr_reg == MAP_AW'(MAP_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_mode == MODE_MARK)
                    begin
                        if (int'(in_byte) < MAP_BYTES)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = MAP_AW'(in_byte);
                            ram_wdata = FULL_BYTE;
                            full_vec_next[MAP_AW'(in_byte)] = 1'b1;
                        end
                        res_bit_next  = '0;
                        res_full_next = 1'b0;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                byte_next = sel_byte;
                if (grp_any && (LIMIT_W'(sel_byte) < limit_sat))
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    res_bit_next  = '0;
                    res_full_next = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_WR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = byte_reg;
                ram_wdata     = new_byte;
                full_vec_next[byte_reg] = (new_byte == FULL_BYTE);
                res_bit_next  = BIT_IDX_W'({byte_reg, free_bit});
                res_full_next = 1'b0;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_bit_next   = res_bit_reg;
                    m_full_next  = res_full_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            full_vec_reg <= '0;
            m_valid_reg  <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            full_vec_reg <= full_vec_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            grp_free_reg <= grp_free_next;
            grp_low_reg  <= grp_low_next;
        end
        byte_reg     <= byte_next;
        res_bit_reg  <= res_bit_next;
        res_full_reg <= res_full_next;
        m_bit_reg    <= m_bit_next;
        m_full_reg   <= m_full_next;
    end

    // The byte chosen for allocation must never read back as fully used.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> ram_rdata != FULL_BYTE)
        else $error("allocation read a byte that is already full");

    // The summary bit of a modified byte follows the written value.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |=> full_vec_reg[$past(byte_reg)] == ($past(ram_wdata) == FULL_BYTE))
        else $error("summary bit disagrees with written map byte");

    // A mark inside the map leaves its byte flagged as full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_mode == MODE_MARK && int'(in_byte) < MAP_BYTES
        |=> full_vec_reg[$past(MAP_AW'(in_byte))])
        else $error("marked byte not flagged full");

    // A full result never carries a bit index.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_full_reg |-> m_bit_reg == '0)
        else $error("full result with nonzero bit index");

endmodule

/* hdl/bfa_ram.sv */
// Generic single-write, single-read memory with registered read data.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
